// ----- rtl/core/alpg_pkg.sv -----
// alpg_pkg: shared types and constants for the adjacent line prefix grouper
// used by alpg_front, alpg_fifo, alpg_back and the top level
`default_nettype none

package alpg_pkg;

  // default depth of the prefix store in bytes
  localparam int unsigned PREFIX_DEPTH_DEF = 1024;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned COUNT_W = 32;

  localparam logic [BYTE_W-1:0]  NEWLINE_BYTE = 8'd10;
  localparam logic [BYTE_W-1:0]  NUL_BYTE     = 8'd0;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

  // depth of the request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // what the front does with an accepted item
  typedef enum logic [1:0] {
    OP_STORE,  // compare one prefix byte and write it to the store
    OP_EOL,    // newline: finish the line
    OP_FLUSH   // end of input: close the last group
  } op_t;

  // one request from front to back
  typedef struct packed {
    logic new_group;
    logic is_final;
  } grp_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/alpg_fifo.sv -----
// alpg_fifo: short request queue between the front and the back
// depends on alpg_pkg (grp_req_t, QUEUE_DEPTH)
`default_nettype none

module alpg_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  alpg_pkg::grp_req_t      push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output alpg_pkg::grp_req_t      pop_data
);

  localparam int unsigned QW = (alpg_pkg::QUEUE_DEPTH > 1) ? $clog2(alpg_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(alpg_pkg::QUEUE_DEPTH + 1);

  alpg_pkg::grp_req_t entry_r [alpg_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign push_ready = (fill_r != NW'(alpg_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(alpg_pkg::QUEUE_DEPTH - 1)) ? '0 : QW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(alpg_pkg::QUEUE_DEPTH - 1)) ? '0 : QW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = NW'(fill_r + 1'b1);
    end else if (do_pop && !do_push) begin
      fill_nxt = NW'(fill_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/alpg_front.sv -----
// alpg_front: accepts text bytes, compares the line prefix against the store
// and decides at each newline whether a new group opens; depends on alpg_pkg
`default_nettype none

module alpg_front #(
  parameter int unsigned PREFIX_DEPTH = alpg_pkg::PREFIX_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [alpg_pkg::CFG_W-1:0]   compare_width,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [alpg_pkg::BYTE_W-1:0]  in_text_byte,
  input  wire logic                         in_end_of_input,
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output alpg_pkg::grp_req_t                push_data
);

  localparam int unsigned AW = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;
  localparam int unsigned PW = $clog2(PREFIX_DEPTH + 1);
  localparam int unsigned CW = (PW > alpg_pkg::CFG_W) ? PW : alpg_pkg::CFG_W;

  // prefix store of the previous line
  logic [alpg_pkg::BYTE_W-1:0] store_mem [PREFIX_DEPTH];
  logic [alpg_pkg::BYTE_W-1:0] rdata_r;

  // accept side state
  logic [PW-1:0] pos_r, pos_nxt;
  logic          line_ended_r, line_ended_nxt;

  // compare stage
  logic                        s1_valid_r, s1_valid_nxt;
  alpg_pkg::op_t               s1_op_r;
  logic [alpg_pkg::BYTE_W-1:0] s1_byte_r;
  logic [PW-1:0]               s1_pos_r;

  // line and group state
  logic [PW-1:0] prev_len_r, prev_len_nxt;
  logic          mismatch_r, mismatch_nxt;
  logic          open_r, open_nxt;

  logic          accept, take, room, is_nl, is_nul;
  alpg_pkg::op_t op_in;
  logic          s1_push, s1_adv, eol_new;

  assign accept = in_valid & in_ready;
  assign is_nl  = (in_text_byte == alpg_pkg::NEWLINE_BYTE);
  assign is_nul = (in_text_byte == alpg_pkg::NUL_BYTE);
  assign room   = (CW'(pos_r) < CW'(compare_width)) && (CW'(pos_r) < CW'(PREFIX_DEPTH));

  always_comb begin
    take  = 1'b0;
    op_in = alpg_pkg::OP_STORE;
    if (in_end_of_input) begin
      take  = 1'b1;
      op_in = alpg_pkg::OP_FLUSH;
    end else if (is_nl) begin
      take  = 1'b1;
      op_in = alpg_pkg::OP_EOL;
    end else if (!line_ended_r && !is_nul && room) begin
      take  = 1'b1;
      op_in = alpg_pkg::OP_STORE;
    end
  end

  always_comb begin
    pos_nxt        = pos_r;
    line_ended_nxt = line_ended_r;
    if (accept) begin
      if (in_end_of_input || is_nl) begin
        pos_nxt        = '0;
        line_ended_nxt = 1'b0;
      end else if (is_nul) begin
        line_ended_nxt = 1'b1;
      end else if (take) begin
        pos_nxt = PW'(pos_r + 1'b1);
      end
    end
  end

  assign s1_push    = s1_valid_r && (s1_op_r != alpg_pkg::OP_STORE);
  assign s1_adv     = !s1_push || push_ready;
  assign in_ready   = s1_adv;
  assign push_valid = s1_push;

  assign eol_new = !open_r || mismatch_r || (s1_pos_r != prev_len_r);

  always_comb begin
    push_data.is_final  = (s1_op_r == alpg_pkg::OP_FLUSH);
    push_data.new_group = (s1_op_r == alpg_pkg::OP_EOL) && eol_new;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = accept && take;
    end
  end

  always_comb begin
    prev_len_nxt = prev_len_r;
    mismatch_nxt = mismatch_r;
    open_nxt     = open_r;
    if (s1_valid_r && s1_adv) begin
      case (s1_op_r)
        alpg_pkg::OP_STORE: begin
          if ((s1_pos_r >= prev_len_r) || (rdata_r != s1_byte_r)) begin
            mismatch_nxt = 1'b1;
          end
        end
        alpg_pkg::OP_EOL: begin
          mismatch_nxt = 1'b0;
          if (eol_new) begin
            prev_len_nxt = s1_pos_r;
            open_nxt     = 1'b1;
          end
        end
        alpg_pkg::OP_FLUSH: begin
          prev_len_nxt = '0;
          mismatch_nxt = 1'b0;
          open_nxt     = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      line_ended_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      prev_len_r   <= '0;
      mismatch_r   <= 1'b0;
      open_r       <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      line_ended_r <= line_ended_nxt;
      s1_valid_r   <= s1_valid_nxt;
      prev_len_r   <= prev_len_nxt;
      mismatch_r   <= mismatch_nxt;
      open_r       <= open_nxt;
    end
  end

  // compare stage payload
  always_ff @(posedge clk) begin
    if (accept && take) begin
      s1_op_r   <= op_in;
      s1_byte_r <= in_text_byte;
      s1_pos_r  <= pos_r;
    end
  end

  // read at accept, write back in the next cycle from the compare stage; a line
  // always moves forward so the read and the write never hit the same entry in the same cycle
  always_ff @(posedge clk) begin
    if (accept && take && (op_in == alpg_pkg::OP_STORE)) begin
      rdata_r <= store_mem[pos_r[AW-1:0]];
    end
    if (s1_valid_r && (s1_op_r == alpg_pkg::OP_STORE)) begin
      store_mem[s1_pos_r[AW-1:0]] <= s1_byte_r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/alpg_back.sv -----
// alpg_back: keeps the running group count and drives the result register
// depends on alpg_pkg (grp_req_t, COUNT_W, COUNT_MAX)
`default_nettype none

module alpg_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  alpg_pkg::grp_req_t                 pop_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_new_group,
  output logic [alpg_pkg::COUNT_W-1:0]       out_closed_count,
  output logic                               out_is_final
);

  logic                         out_valid_r, out_valid_nxt;
  logic                         new_group_r;
  logic                         is_final_r;
  logic [alpg_pkg::COUNT_W-1:0] closed_r, closed_nxt;
  logic [alpg_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                         open_r, open_nxt;
  logic                         take;

  assign pop_ready = !out_valid_r || out_ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    closed_nxt    = '0;
    count_nxt     = count_r;
    open_nxt      = open_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
      if (pop_data.is_final || pop_data.new_group) begin
        closed_nxt = open_r ? count_r : '0;
      end
      if (pop_data.is_final) begin
        count_nxt = '0;
        open_nxt  = 1'b0;
      end else if (pop_data.new_group) begin
        count_nxt = alpg_pkg::COUNT_W'(1);
        open_nxt  = 1'b1;
      end else if (count_r != alpg_pkg::COUNT_MAX) begin
        count_nxt = alpg_pkg::COUNT_W'(count_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      open_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      open_r      <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      new_group_r <= pop_data.new_group;
      is_final_r  <= pop_data.is_final;
      closed_r    <= closed_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_group    = new_group_r;
  assign out_closed_count = closed_r;
  assign out_is_final     = is_final_r;

endmodule

`default_nettype wire

// ----- rtl/core/adjacent_line_prefix_grouper.sv -----
// adjacent_line_prefix_grouper: top level of the line prefix grouper
// holds the width register; uses alpg_pkg, alpg_front, alpg_fifo, alpg_back
`default_nettype none

// Groups adjacent lines of a byte stream (uniq -w style). Each request is one
// text byte or an end marker. A newline byte ends a line; the line's first
// compare_width bytes (capped at PREFIX_DEPTH, cut short at a zero byte) are
// compared with the previous line's, and one result tells whether the line
// opens a new group plus the saturating count of the group it closes (0 if
// none). The first line always opens a group. An end marker gives one result
// with is_final set and the last group's count, and drops any unterminated
// line. Ordinary bytes give no result. The block takes one request per cycle
// sustained: each byte costs one read and one write of the prefix store (read
// at accept, compare and write back the next cycle). Results go through a
// two-entry queue and an output register, so a stalled result side drops
// in_ready once four newline or end requests wait (one in the output
// register, two in the queue, one in the compare stage). No clearing pass is
// needed after reset. compare_width may be written only while the block is
// idle.

module adjacent_line_prefix_grouper #(
  parameter int unsigned PREFIX_DEPTH = alpg_pkg::PREFIX_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // width register
  input  wire logic                          cfg_write_en,
  input  wire logic [alpg_pkg::CFG_W-1:0]    cfg_write_data,
  // byte requests
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [alpg_pkg::BYTE_W-1:0]   in_text_byte,
  input  wire logic                          in_end_of_input,
  // results
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_new_group,
  output logic [alpg_pkg::COUNT_W-1:0]       out_closed_count,
  output logic                               out_is_final
);

  // compare width register
  logic [alpg_pkg::CFG_W-1:0] compare_width_r, compare_width_nxt;

  // front to queue
  logic               push_valid, push_ready;
  alpg_pkg::grp_req_t push_data;

  // queue to back
  logic               pop_valid, pop_ready;
  alpg_pkg::grp_req_t pop_data;

  assign compare_width_nxt = cfg_write_en ? cfg_write_data : compare_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_width_r <= '0;
    end else begin
      compare_width_r <= compare_width_nxt;
    end
  end

  // front: classifies bytes, runs the prefix compare, decides group openings
  alpg_front #(
    .PREFIX_DEPTH (PREFIX_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .compare_width   (compare_width_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_end_of_input (in_end_of_input),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  // short queue so the front keeps going while a result waits
  alpg_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: group counting and the result register
  alpg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_group    (out_new_group),
    .out_closed_count (out_closed_count),
    .out_is_final     (out_is_final)
  );

endmodule

`default_nettype wire
